// ===== rtl/fas_pkg.sv =====
// shared types and constants for the float32 add/subtract pipeline
`default_nettype none
package fas_pkg;
    localparam logic [31:0] SIGN_MASK  = 32'h8000_0000;
    localparam logic [31:0] MANT_FIELD = 32'h3FFF_FF80;
    localparam logic [31:0] HIDDEN_ONE = 32'h4000_0000;
    localparam int          LZ_W       = 5;

    localparam logic REQ_ADD = 1'b0;
    localparam logic REQ_SUB = 1'b1;

    // aligned operands
    typedef struct packed {
        logic               req_sub;
        logic               bypass;
        logic [31:0]        bypass_bits;
        logic signed [31:0] frac_a;
        logic signed [31:0] frac_b;
        logic [7:0]         exp_max;
    } align_t;

    // raw signed sum
    typedef struct packed {
        logic               bypass;
        logic [31:0]        bypass_bits;
        logic signed [31:0] sum;
        logic [7:0]         exp_max;
    } sum_t;

    // magnitude with leading zero count
    typedef struct packed {
        logic             bypass;
        logic [31:0]      bypass_bits;
        logic             is_zero;
        logic             sign;
        logic [30:0]      mag;
        logic [LZ_W-1:0]  lz;
        logic [7:0]       exp_max;
    } norm_t;
endpackage
`default_nettype wire

// ===== rtl/fas_align.sv =====
// stage 1: zero detect, unpack, exponent compare and alignment shift
`default_nettype none
module fas_align
    import fas_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic        req_type,
    input  wire logic [31:0] operand_a,
    input  wire logic [31:0] operand_b,
    output logic             out_valid,
    input  wire logic        out_ready,
    output align_t           out_data
);
    logic   valid_reg, valid_next;
    align_t data_reg, data_next;

    logic               a_zero, b_zero;
    logic signed [31:0] fa, fb;
    logic [7:0]         ea, eb;
    logic [8:0]         diff;
    logic [7:0]         exp_gap;
    logic [4:0]         sh;

    always_comb begin
        a_zero = (operand_a & ~SIGN_MASK) == 32'd0;
        b_zero = (operand_b & ~SIGN_MASK) == 32'd0;
        fa = ((operand_a << 7) & MANT_FIELD) | HIDDEN_ONE;
        fb = ((operand_b << 7) & MANT_FIELD) | HIDDEN_ONE;
        if (operand_a[31]) begin
            fa = -fa;
        end
        if (operand_b[31]) begin
            fb = -fb;
        end
        ea      = operand_a[30:23];
        eb      = operand_b[30:23];
        diff    = {1'b0, ea} - {1'b0, eb};
        exp_gap = diff[8] ? (eb - ea) : (ea - eb);
        sh      = (exp_gap > 8'd31) ? 5'd31 : exp_gap[4:0];

        data_next.req_sub     = req_type;
        data_next.bypass      = a_zero || b_zero;
        data_next.bypass_bits = 32'd0;
        if (a_zero && b_zero) begin
            data_next.bypass_bits = 32'd0;
        end else if (b_zero) begin
            data_next.bypass_bits = operand_a;
        end else if (a_zero) begin
            data_next.bypass_bits = (req_type == REQ_SUB) ? (operand_b ^ SIGN_MASK) : operand_b;
        end
        if (diff[8]) begin
            data_next.frac_a  = fa >>> sh;
            data_next.frac_b  = fb;
            data_next.exp_max = eb;
        end else begin
            data_next.frac_a  = fa;
            data_next.frac_b  = fb >>> sh;
            data_next.exp_max = ea;
        end
    end

    assign in_ready   = !valid_reg || out_ready;
    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;
endmodule
`default_nettype wire

// ===== rtl/fas_addsub.sv =====
// stage 2: halve both fractions and add or subtract
`default_nettype none
module fas_addsub
    import fas_pkg::*;
(
    input  wire logic   aclk,
    input  wire logic   aresetn,
    input  wire logic   in_valid,
    output logic        in_ready,
    input  wire align_t in_data,
    output logic        out_valid,
    input  wire logic   out_ready,
    output sum_t        out_data
);
    logic valid_reg, valid_next;
    sum_t data_reg, data_next;
    logic signed [31:0] ha, hb;

    always_comb begin
        ha = in_data.frac_a >>> 1;
        hb = in_data.frac_b >>> 1;
        data_next.bypass      = in_data.bypass;
        data_next.bypass_bits = in_data.bypass_bits;
        data_next.sum         = (in_data.req_sub == REQ_SUB) ? (ha - hb) : (ha + hb);
        data_next.exp_max     = in_data.exp_max;
    end

    assign in_ready   = !valid_reg || out_ready;
    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;
endmodule
`default_nettype wire

// ===== rtl/fas_lzc.sv =====
// stage 3: sign and magnitude, leading zero count below bit 30
`default_nettype none
module fas_lzc
    import fas_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic in_valid,
    output logic      in_ready,
    input  wire sum_t in_data,
    output logic      out_valid,
    input  wire logic out_ready,
    output norm_t     out_data
);
    logic        valid_reg, valid_next;
    norm_t       data_reg, data_next;
    logic [31:0] mag_full;
    logic [LZ_W-1:0] lz;

    always_comb begin
        mag_full = in_data.sum[31] ? (32'd0 - in_data.sum) : in_data.sum;
        lz = '0;
        // highest set bit wins
        for (int i = 0; i < 31; i++) begin
            if (mag_full[i]) begin
                lz = LZ_W'(30 - i);
            end
        end
        data_next.bypass      = in_data.bypass;
        data_next.bypass_bits = in_data.bypass_bits;
        data_next.is_zero     = in_data.sum == 32'sd0;
        data_next.sign        = in_data.sum[31];
        data_next.mag         = mag_full[30:0];
        data_next.lz          = lz;
        data_next.exp_max     = in_data.exp_max;
    end

    assign in_ready   = !valid_reg || out_ready;
    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;
endmodule
`default_nettype wire

// ===== rtl/float32_add_sub_truncating_unit.sv =====
// float32 add/subtract pipeline top: stages and final normalize/pack register
// path: stage 1, stage 2 and stage 3 registers, then the output register, before m_valid rises (four registers)
// throughput: one item per cycle while m_ready stays high, each stage reloads in the cycle its item moves on
// each stage holds while its successor stalls, so backpressure loses nothing
// reset: synchronous active-low aresetn clears all stage valid bits
`default_nettype none
module float32_add_sub_truncating_unit
    import fas_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic        s_req_type,
    input  wire logic [31:0] s_operand_a,
    input  wire logic [31:0] s_operand_b,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [31:0]      m_sum_bits
);
    logic   v1, r1, v2, r2, v3, r3;
    align_t d1;
    sum_t   d2;
    norm_t  d3;

    fas_align u_align (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(s_valid), .in_ready(s_ready),
        .req_type(s_req_type), .operand_a(s_operand_a), .operand_b(s_operand_b),
        .out_valid(v1), .out_ready(r1), .out_data(d1)
    );

    fas_addsub u_addsub (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(v1), .in_ready(r1), .in_data(d1),
        .out_valid(v2), .out_ready(r2), .out_data(d2)
    );

    fas_lzc u_lzc (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(v2), .in_ready(r2), .in_data(d2),
        .out_valid(v3), .out_ready(r3), .out_data(d3)
    );

    logic        valid_reg, valid_next;
    logic [31:0] sum_reg, sum_next;
    logic [30:0] shifted;
    logic [7:0]  exp_out;

    always_comb begin
        shifted = d3.mag << d3.lz;
        // biased exponent: larger field plus one for the halving, minus shift, wraps
        exp_out = d3.exp_max + 8'd1 - {{(8 - LZ_W){1'b0}}, d3.lz};
        if (d3.bypass) begin
            sum_next = d3.bypass_bits;
        end else if (d3.is_zero) begin
            sum_next = 32'd0;
        end else begin
            sum_next = {d3.sign, exp_out, shifted[29:7]};
        end
    end

    assign r3         = !valid_reg || m_ready;
    assign valid_next = r3 ? v3 : valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        if (r3 && v3) begin
            sum_reg <= sum_next;
        end
    end

    assign m_valid    = valid_reg;
    assign m_sum_bits = sum_reg;

    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");
    a_full_when_blocked: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (v1 && v2 && v3 && m_valid))
        else $error("input blocked while pipeline has a bubble");
    a_norm_bit: assert property (@(posedge aclk) disable iff (!aresetn)
        (v3 && !d3.bypass && !d3.is_zero) |-> shifted[30])
        else $error("normalized magnitude lacks leading one");
    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (v3 && !r3) |=> v3)
        else $error("stage 3 item lost during stall");
endmodule
`default_nettype wire

// ===== bench/float32_add_sub_truncating_unit_tb.sv =====
// self-checking testbench for the float32 add/subtract truncating pipeline
`default_nettype none
module float32_add_sub_truncating_unit_tb
    import fas_pkg::*;
();

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic        s_req_type = REQ_ADD;
    logic [31:0] s_operand_a = '0;
    logic [31:0] s_operand_b = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [31:0] m_sum_bits;

    typedef struct {
        logic        op;
        logic [31:0] a;
        logic [31:0] b;
        logic        known;
        logic [31:0] sum;
    } vec_t;

    logic [31:0] sum_queue[$];
    int          n_errors = 0;
    bit          stim_done = 1'b0;
    bit          hold_long = 1'b0;

    float32_add_sub_truncating_unit DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_req_type(s_req_type),
        .s_operand_a(s_operand_a), .s_operand_b(s_operand_b),
        .m_valid(m_valid), .m_ready(m_ready), .m_sum_bits(m_sum_bits)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    function automatic longint shr_signed(longint v, int n);
        if (n > 62) n = 62;
        return v >>> n;
    endfunction

    function automatic logic [31:0] float_add_sub(logic op, logic [31:0] a, logic [31:0] b);
        longint      fa, fb, r, mag;
        int          ea, eb, er, diff;
        logic [31:0] res;
        bit          az, bz;
        az = (a & ~SIGN_MASK) == 0;
        bz = (b & ~SIGN_MASK) == 0;
        if (az && bz) return 32'h0;
        if (bz) return a;
        if (az) return (op == REQ_SUB) ? (b ^ SIGN_MASK) : b;
        fa = longint'(((a << 7) & MANT_FIELD) | HIDDEN_ONE);
        fb = longint'(((b << 7) & MANT_FIELD) | HIDDEN_ONE);
        if (a[31]) fa = -fa;
        if (b[31]) fb = -fb;
        ea = int'(a[30:23]) - 127;
        eb = int'(b[30:23]) - 127;
        diff = ea - eb;
        if (diff > 0) begin
            fb = shr_signed(fb, diff > 31 ? 31 : diff);
            er = ea;
        end else begin
            if (diff < 0) fa = shr_signed(fa, -diff > 31 ? 31 : -diff);
            er = eb;
        end
        r = (op == REQ_SUB) ? shr_signed(fa, 1) - shr_signed(fb, 1)
                            : shr_signed(fa, 1) + shr_signed(fb, 1);
        er = er + 1;
        if (r == 0) return 32'h0;
        mag = r < 0 ? -r : r;
        while ((mag & longint'(HIDDEN_ONE)) == 0) begin
            mag = mag <<< 1;
            er = er - 1;
        end
        res = r < 0 ? SIGN_MASK : 32'h0;
        res[30:23] = 8'(er + 127);
        res[22:0] = 23'(mag >>> 7);
        return res;
    endfunction

    // directed rows; known marks a result readable at a glance
    vec_t directed[] = '{
        '{REQ_ADD, 32'h0000_0000, 32'h0000_0000, 1'b1, 32'h0000_0000},
        '{REQ_SUB, 32'h8000_0000, 32'h8000_0000, 1'b1, 32'h0000_0000},
        '{REQ_ADD, 32'h3F80_0000, 32'h0000_0000, 1'b1, 32'h3F80_0000},
        '{REQ_SUB, 32'hC120_0000, 32'h8000_0000, 1'b1, 32'hC120_0000},
        '{REQ_ADD, 32'h0000_0000, 32'h4040_0000, 1'b1, 32'h4040_0000},
        '{REQ_SUB, 32'h8000_0000, 32'h4040_0000, 1'b1, 32'hC040_0000},
        '{REQ_SUB, 32'h3F80_0000, 32'h3F80_0000, 1'b1, 32'h0000_0000},
        '{REQ_ADD, 32'h3F80_0000, 32'hBF80_0000, 1'b1, 32'h0000_0000},
        '{REQ_ADD, 32'h3F80_0000, 32'h3F80_0000, 1'b0, 32'h0},
        '{REQ_ADD, 32'h3F80_0000, 32'h4000_0000, 1'b0, 32'h0},
        '{REQ_SUB, 32'h3F80_0000, 32'hBF80_0000, 1'b0, 32'h0},
        '{REQ_SUB, 32'h3F80_0000, 32'h3F7F_FFFF, 1'b0, 32'h0},
        '{REQ_ADD, 32'h7F7F_FFFF, 32'h7F7F_FFFF, 1'b0, 32'h0},
        '{REQ_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 32'h0},
        '{REQ_SUB, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b0, 32'h0},
        '{REQ_ADD, 32'h0000_0001, 32'h0000_0001, 1'b0, 32'h0},
        '{REQ_ADD, 32'h4B00_0000, 32'h0080_0000, 1'b0, 32'h0},
        '{REQ_ADD, 32'h4B00_0000, 32'h8080_0000, 1'b0, 32'h0},
        '{REQ_SUB, 32'h0080_0000, 32'h7F00_0000, 1'b0, 32'h0},
        '{REQ_ADD, 32'h3F80_0000, 32'h3380_0000, 1'b0, 32'h0},
        '{REQ_SUB, 32'hAAAA_AAAA, 32'h5555_5555, 1'b0, 32'h0},
        '{REQ_ADD, 32'h5555_5555, 32'hAAAA_AAAA, 1'b0, 32'h0}
    };

    task automatic send_item(logic op, logic [31:0] a, logic [31:0] b,
                             logic known, logic [31:0] sum);
        s_valid     <= 1'b1;
        s_req_type  <= op;
        s_operand_a <= a;
        s_operand_b <= b;
        sum_queue.push_back(known ? sum : float_add_sub(op, a, b));
        do @(posedge aclk); while (!s_ready);
    endtask

    function automatic logic [31:0] rand_float();
        logic [31:0] v;
        v = $urandom;
        case ($urandom_range(0, 5))
            0: v[30:0] = '0;
            1: v[30:23] = 8'd127 + 8'($urandom_range(0, 6)) - 8'd3;
            2: v[30:23] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            default: ;
        endcase
        return v;
    endfunction

    initial begin
        logic [31:0] a, b;
        logic        op;
        int          gap, burst;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        foreach (directed[i]) begin
            send_item(directed[i].op, directed[i].a, directed[i].b,
                      directed[i].known, directed[i].sum);
        end
        s_valid <= 1'b0;
        // drain fully before the random part
        while (sum_queue.size() != 0) @(posedge aclk);
        hold_long <= 1'b1;
        for (int n = 0; n < 950; ) begin
            burst = $urandom_range(1, 20);
            for (int k = 0; k < burst && n < 950; k++, n++) begin
                op = 1'($urandom_range(0, 1));
                a = rand_float();
                b = ($urandom_range(0, 3) == 0) ? (a ^ (32'($urandom_range(0, 1)) << 31))
                                                : rand_float();
                send_item(op, a, b, 1'b0, 32'h0);
            end
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        s_valid <= 1'b0;
        stim_done = 1'b1;
    end

    // receiver: one long hold-off during the random part, then a stall pattern
    initial begin
        int pat;
        @(posedge aresetn);
        m_ready <= 1'b1;
        wait (hold_long);
        @(posedge aclk);
        m_ready <= 1'b0;
        repeat (60) @(posedge aclk);
        forever begin
            pat = $urandom_range(0, 15);
            m_ready <= (pat < 11);
            @(posedge aclk);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (sum_queue.size() == 0) begin
                $error("unexpected result sum_bits=%h", m_sum_bits);
                n_errors++;
            end else begin
                logic [31:0] want;
                want = sum_queue.pop_front();
                if (m_sum_bits !== want) begin
                    $error("sum_bits mismatch: expected %h actual %h", want, m_sum_bits);
                    n_errors++;
                end
            end
        end
    end

    initial begin
        wait (stim_done);
        while (sum_queue.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (n_errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    initial begin
        #200000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
`default_nettype wire
